/* rtl/core/cau_pkg.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Operation codes and the control word that travels down the pipeline.
// ----------------------------------------------------------------------------
package cau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic big_re;
    logic big_im;
  } ctrl_t;

endpackage

/* rtl/core/complex_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipeline: operand, product, combine, sign/magnitude and dividend-scale
//   registers, then the one-bit-per-stage divider pipeline and the output
//   register, in that order, for every operation.
// Throughput: one transaction per cycle for every operation; busy is low
//   except in reset, and the receiver cannot stall.
// Reset: synchronous rst clears all valid bits; busy is high during reset.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 28
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  cau_pkg::op_t                operation,
  input  logic signed [WORD_BITS-1:0] a_re,
  input  logic signed [WORD_BITS-1:0] a_im,
  input  logic signed [WORD_BITS-1:0] b_re,
  input  logic signed [WORD_BITS-1:0] b_im,
  output logic                        done,
  output logic signed [WORD_BITS-1:0] res_re,
  output logic signed [WORD_BITS-1:0] res_im,
  output logic                        div_zero,
  output logic                        overflowed
);
  import cau_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int TW  = (W + F > 2 * W) ? (W + F) : (2 * W);
  localparam int XW  = TW + W;
  localparam int LAT = W + 6;

  assign busy = rst;

  // stage 1: operands
  logic                s1_valid;
  op_t                 s1_op;
  logic signed [W-1:0] s1_ar, s1_ai, s1_br, s1_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    s1_op <= operation;
    s1_ar <= a_re;
    s1_ai <= a_im;
    s1_br <= b_re;
    s1_bi <= b_im;
  end

  // stage 2: products and plain sums
  logic                  s2_valid;
  op_t                   s2_op;
  logic signed [2*W-1:0] p_ac, p_bd, p_ad, p_bc, p_cc, p_dd;
  logic signed [W:0]     s2_sre, s2_sim;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_op <= s1_op;
    p_ac  <= s1_ar * s1_br;
    p_bd  <= s1_ai * s1_bi;
    p_ad  <= s1_ar * s1_bi;
    p_bc  <= s1_ai * s1_br;
    p_cc  <= s1_br * s1_br;
    p_dd  <= s1_bi * s1_bi;
    if (s1_op == OP_SUB) begin
      s2_sre <= (W+1)'(s1_ar) - (W+1)'(s1_br);
      s2_sim <= (W+1)'(s1_ai) - (W+1)'(s1_bi);
    end else begin
      s2_sre <= (W+1)'(s1_ar) + (W+1)'(s1_br);
      s2_sim <= (W+1)'(s1_ai) + (W+1)'(s1_bi);
    end
  end

  // stage 3: combine
  logic                s3_valid;
  op_t                 s3_op;
  logic signed [2*W:0] v_re, v_im, v_re_next, v_im_next;
  logic [2*W-1:0]      s3_den;

  always_comb begin
    case (s2_op)
      OP_MUL: begin
        v_re_next = (2*W+1)'(p_ac) - (2*W+1)'(p_bd);
        v_im_next = (2*W+1)'(p_ad) + (2*W+1)'(p_bc);
      end
      OP_DIV: begin
        v_re_next = (2*W+1)'(p_ac) + (2*W+1)'(p_bd);
        v_im_next = (2*W+1)'(p_bc) - (2*W+1)'(p_ad);
      end
      default: begin
        v_re_next = (2*W+1)'(s2_sre);
        v_im_next = (2*W+1)'(s2_sim);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_op  <= s2_op;
    v_re   <= v_re_next;
    v_im   <= v_im_next;
    s3_den <= p_cc[2*W-1:0] + p_dd[2*W-1:0];
  end

  // stage 4: sign and magnitude
  ctrl_t          s4_ctrl, s4_ctrl_next;
  logic [2*W-1:0] s4_mre, s4_mim, s4_den;
  logic [2*W:0]   abs_re, abs_im, sh_re, sh_im;
  logic [2*W-1:0] mre_next, mim_next;

  always_comb begin
    abs_re = v_re[2*W] ? -v_re : v_re;
    abs_im = v_im[2*W] ? -v_im : v_im;
    sh_re  = abs_re >> F;
    sh_im  = abs_im >> F;
    if (s3_op == OP_MUL) begin
      mre_next = sh_re[2*W-1:0];
      mim_next = sh_im[2*W-1:0];
    end else begin
      mre_next = abs_re[2*W-1:0];
      mim_next = abs_im[2*W-1:0];
    end
    s4_ctrl_next.valid  = s3_valid;
    s4_ctrl_next.is_div = (s3_op == OP_DIV);
    s4_ctrl_next.dz     = (s3_op == OP_DIV) && (s3_den == '0);
    s4_ctrl_next.neg_re = v_re[2*W];
    s4_ctrl_next.neg_im = v_im[2*W];
    s4_ctrl_next.big_re = 1'b0;
    s4_ctrl_next.big_im = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctrl <= '0;
    end else begin
      s4_ctrl <= s4_ctrl_next;
    end
    s4_mre <= mre_next;
    s4_mim <= mim_next;
    s4_den <= s3_den;
  end

  // stage 5: scale dividend, check quotient range, seed remainder
  ctrl_t          d_ctrl [W+1];
  logic [2*W-1:0] d_den  [W+1];
  logic [2*W-1:0] d_rre  [W+1];
  logic [2*W-1:0] d_rim  [W+1];
  logic [W-1:0]   d_lre  [W+1];
  logic [W-1:0]   d_lim  [W+1];
  logic [XW-1:0]  x_re, x_im;
  logic [TW-1:0]  t_re, t_im;
  ctrl_t          s5_ctrl_next;

  always_comb begin
    x_re = XW'(s4_mre) << F;
    x_im = XW'(s4_mim) << F;
    t_re = x_re[XW-1:W];
    t_im = x_im[XW-1:W];
    s5_ctrl_next        = s4_ctrl;
    s5_ctrl_next.big_re = s4_ctrl.is_div && (t_re >= TW'(s4_den));
    s5_ctrl_next.big_im = s4_ctrl.is_div && (t_im >= TW'(s4_den));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_ctrl[0] <= '0;
    end else begin
      d_ctrl[0] <= s5_ctrl_next;
    end
    d_den[0] <= s4_den;
    d_rre[0] <= s4_ctrl.is_div ? t_re[2*W-1:0] : s4_mre;
    d_rim[0] <= s4_ctrl.is_div ? t_im[2*W-1:0] : s4_mim;
    d_lre[0] <= x_re[W-1:0];
    d_lim[0] <= x_im[W-1:0];
  end

  // divider: one quotient bit per stage
  for (genvar i = 0; i < W; i++) begin : g_div
    cau_div_step #(.W(W)) u_step (
      .clk        (clk),
      .rst        (rst),
      .ctrl_in    (d_ctrl[i]),
      .den_in     (d_den[i]),
      .rem_re_in  (d_rre[i]),
      .rem_im_in  (d_rim[i]),
      .lq_re_in   (d_lre[i]),
      .lq_im_in   (d_lim[i]),
      .ctrl_out   (d_ctrl[i+1]),
      .den_out    (d_den[i+1]),
      .rem_re_out (d_rre[i+1]),
      .rem_im_out (d_rim[i+1]),
      .lq_re_out  (d_lre[i+1]),
      .lq_im_out  (d_lim[i+1])
    );
  end

  // output stage: saturate and register
  ctrl_t               fc;
  logic [2*W-1:0]      fm_re, fm_im;
  logic signed [W-1:0] w_re, w_im;
  logic                o_re, o_im;

  assign fc    = d_ctrl[W];
  assign fm_re = fc.is_div ? (2*W)'(d_lre[W]) : d_rre[W];
  assign fm_im = fc.is_div ? (2*W)'(d_lim[W]) : d_rim[W];

  cau_sat #(.W(W)) u_sat_re (
    .neg  (fc.neg_re),
    .big  (fc.big_re),
    .mag  (fm_re),
    .word (w_re),
    .ovf  (o_re)
  );

  cau_sat #(.W(W)) u_sat_im (
    .neg  (fc.neg_im),
    .big  (fc.big_im),
    .mag  (fm_im),
    .word (w_im),
    .ovf  (o_im)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fc.valid;
    end
    if (fc.dz) begin
      res_re     <= '0;
      res_im     <= '0;
      overflowed <= 1'b0;
    end else begin
      res_re     <= w_re;
      res_im     <= w_im;
      overflowed <= o_re || o_im;
    end
    div_zero <= fc.dz;
  end

  localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("transaction result missing after pipeline latency");

  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    (done && div_zero) |-> (res_re == '0 && res_im == '0 && !overflowed))
    else $error("zero divisor result not cleared");

  a_ovf_clamp: assert property (@(posedge clk) disable iff (rst)
    (done && overflowed) |->
      (res_re == MAXW || res_re == MINW || res_im == MAXW || res_im == MINW))
    else $error("overflow flagged without a clamped part");

endmodule

/* rtl/core/cau_div_step.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit divider step
// One restoring quotient bit for the real and imaginary lanes, registered.
// ----------------------------------------------------------------------------
module cau_div_step #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cau_pkg::ctrl_t        ctrl_in,
  input  logic [2*W-1:0]        den_in,
  input  logic [2*W-1:0]        rem_re_in,
  input  logic [2*W-1:0]        rem_im_in,
  input  logic [W-1:0]          lq_re_in,
  input  logic [W-1:0]          lq_im_in,
  output cau_pkg::ctrl_t        ctrl_out,
  output logic [2*W-1:0]        den_out,
  output logic [2*W-1:0]        rem_re_out,
  output logic [2*W-1:0]        rem_im_out,
  output logic [W-1:0]          lq_re_out,
  output logic [W-1:0]          lq_im_out
);
  import cau_pkg::*;

  logic [2*W:0]   rem2_re, rem2_im, diff_re, diff_im;
  logic           ge_re, ge_im;
  logic [2*W-1:0] rem_re_next, rem_im_next;
  logic [W-1:0]   lq_re_next, lq_im_next;

  always_comb begin
    rem2_re = {rem_re_in, lq_re_in[W-1]};
    rem2_im = {rem_im_in, lq_im_in[W-1]};
    ge_re   = rem2_re >= {1'b0, den_in};
    ge_im   = rem2_im >= {1'b0, den_in};
    diff_re = rem2_re - {1'b0, den_in};
    diff_im = rem2_im - {1'b0, den_in};
    if (ctrl_in.is_div) begin
      rem_re_next = ge_re ? diff_re[2*W-1:0] : rem2_re[2*W-1:0];
      rem_im_next = ge_im ? diff_im[2*W-1:0] : rem2_im[2*W-1:0];
      lq_re_next  = {lq_re_in[W-2:0], ge_re};
      lq_im_next  = {lq_im_in[W-2:0], ge_im};
    end else begin
      rem_re_next = rem_re_in;
      rem_im_next = rem_im_in;
      lq_re_next  = lq_re_in;
      lq_im_next  = lq_im_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out <= '0;
    end else begin
      ctrl_out <= ctrl_in;
    end
    den_out    <= den_in;
    rem_re_out <= rem_re_next;
    rem_im_out <= rem_im_next;
    lq_re_out  <= lq_re_next;
    lq_im_out  <= lq_im_next;
  end

endmodule

/* rtl/core/cau_sat.sv */
// ----------------------------------------------------------------------------
// Complex arithmetic unit saturation
// Clamp a sign and magnitude pair to the signed word range.
// ----------------------------------------------------------------------------
module cau_sat #(
  parameter int W = 32
) (
  input  logic                neg,
  input  logic                big,
  input  logic [2*W-1:0]      mag,
  output logic signed [W-1:0] word,
  output logic                ovf
);

  logic [2*W-1:0] lim, m;
  logic           isneg;

  always_comb begin
    lim   = ((2*W)'(1) << (W - 1)) - (2*W)'(!neg);
    ovf   = big || (mag > lim);
    m     = ovf ? lim : mag;
    isneg = neg && (m != '0);
    word  = isneg ? -m[W-1:0] : m[W-1:0];
  end

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Complex arithmetic unit testbench
// Drives add, subtract, multiply and divide transactions from a directed
// table, then at random; uses the table's result where given, else exact
// wide integer prediction, and checks every strobed result in order.
// ----------------------------------------------------------------------------
module testbench;
  import cau_pkg::*;

  localparam int W = 32;
  localparam int F = 28;
  localparam logic signed [W-1:0] WMAX = 32'sh7fffffff;
  localparam logic signed [W-1:0] WMIN = 32'sh80000000;
  localparam logic signed [W-1:0] ONE  = 32'sh10000000;

  typedef struct {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic                dz;
    logic                ovf;
  } cplx_result_t;

  typedef struct {
    op_t                 op;
    logic signed [W-1:0] ar, ai, br, bi;
    bit                  known;
    cplx_result_t        res;
  } stim_row_t;

  logic clk, rst, start, busy, done, div_zero, overflowed;
  op_t operation;
  logic signed [W-1:0] a_re, a_im, b_re, b_im, res_re, res_im;

  cplx_result_t pending_results[$];
  cplx_result_t next_known[$];
  bit           next_is_known[$];
  int mismatches = 0;

  complex_arithmetic_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im), .done(done),
    .res_re(res_re), .res_im(res_im), .div_zero(div_zero), .overflowed(overflowed)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("** complex_arithmetic_unit: FAILED **");
    $finish;
  end

  function automatic logic signed [127:0] drop_frac(input logic signed [127:0] v);
    if (v < 0) begin
      return -((-v) >>> F);
    end
    return v >>> F;
  endfunction

  function automatic logic signed [W-1:0] clamp(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > WMAX) begin
      ovf = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      ovf = 1;
      return WMIN;
    end
    return v[W-1:0];
  endfunction

  function automatic cplx_result_t complex_op(input op_t op,
      input logic signed [W-1:0] ar, ai, br, bi);
    logic signed [127:0] xr, xi, yr, yi, vr, vi, mag2;
    cplx_result_t r;
    xr = ar; xi = ai; yr = br; yi = bi;
    r.dz = 0;
    r.ovf = 0;
    case (op)
      OP_ADD: begin
        vr = xr + yr; vi = xi + yi;
      end
      OP_SUB: begin
        vr = xr - yr; vi = xi - yi;
      end
      OP_MUL: begin
        vr = drop_frac(xr * yr - xi * yi);
        vi = drop_frac(xr * yi + xi * yr);
      end
      default: begin
        mag2 = yr * yr + yi * yi;
        if (mag2 == 0) begin
          r.dz = 1; vr = 0; vi = 0;
        end else begin
          vr = ((xr * yr + xi * yi) <<< F) / mag2;
          vi = ((xi * yr - xr * yi) <<< F) / mag2;
        end
      end
    endcase
    r.re = clamp(vr, r.ovf);
    r.im = clamp(vi, r.ovf);
    return r;
  endfunction

  // expectations are queued on acceptance; results are checked on the strobe
  always @(posedge clk) begin
    cplx_result_t e;
    if (!rst && start && !busy) begin
      if (next_is_known.size() > 0 && next_is_known.pop_front()) begin
        pending_results.push_back(next_known.pop_front());
      end else begin
        pending_results.push_back(complex_op(operation, a_re, a_im, b_re, b_im));
      end
    end
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result re=%h im=%h", res_re, res_im);
        end
      end else begin
        e = pending_results.pop_front();
        if (res_re !== e.re || res_im !== e.im || div_zero !== e.dz ||
            overflowed !== e.ovf) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: exp re=%h im=%h dz=%b ovf=%b, got re=%h im=%h dz=%b ovf=%b",
                     e.re, e.im, e.dz, e.ovf, res_re, res_im, div_zero, overflowed);
          end
        end
      end
    end
  end

  task automatic issue(input op_t op, input logic signed [W-1:0] ar, ai, br, bi,
                       input int idle_pct);
    int gap;
    if ($urandom_range(99) < idle_pct) begin
      gap = $urandom_range(1, 5);
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    operation <= op;
    a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  function automatic logic signed [W-1:0] rand_part(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3fffffff)) - 32'sh20000000;
      2: return $signed($urandom_range(0, 32'h0fffff)) - 32'sh080000;
      default: begin
        case ($urandom_range(3))
          0: return WMAX;
          1: return WMIN;
          2: return 0;
          default: return ONE;
        endcase
      end
    endcase
  endfunction

  function automatic cplx_result_t known(input logic signed [W-1:0] re, im,
                                         input logic dz, ovf);
    cplx_result_t r;
    r.re = re; r.im = im; r.dz = dz; r.ovf = ovf;
    return r;
  endfunction

  stim_row_t rows[$];

  initial begin
    int idle_pct, kind;
    logic signed [W-1:0] br, bi;
    op_t op;
    rst = 1; start = 0; operation = OP_ADD;
    a_re = 0; a_im = 0; b_re = 0; b_im = 0;

    rows.push_back('{OP_ADD, 0, 0, 0, 0, 1, known(0, 0, 0, 0)});
    rows.push_back('{OP_ADD, WMAX, WMAX, WMAX, WMAX, 1, known(WMAX, WMAX, 0, 1)});
    rows.push_back('{OP_ADD, WMIN, WMIN, WMIN, WMIN, 1, known(WMIN, WMIN, 0, 1)});
    rows.push_back('{OP_ADD, 1, -1, -1, 1, 1, known(0, 0, 0, 0)});
    rows.push_back('{OP_SUB, 0, 0, WMIN, WMAX, 1, known(WMAX, -WMAX, 0, 1)});
    rows.push_back('{OP_SUB, WMIN, WMAX, WMAX, WMIN, 1, known(WMIN, WMAX, 0, 1)});
    rows.push_back('{OP_SUB, ONE, ONE, ONE, ONE, 1, known(0, 0, 0, 0)});
    rows.push_back('{OP_MUL, ONE, 0, 0, ONE, 1, known(0, ONE, 0, 0)});
    rows.push_back('{OP_MUL, WMAX, WMAX, WMAX, WMAX, 1, known(0, WMAX, 0, 1)});
    rows.push_back('{OP_MUL, WMIN, WMIN, WMIN, WMIN, 1, known(0, WMAX, 0, 1)});
    rows.push_back('{OP_MUL, WMIN, 0, WMIN, 0, 1, known(WMAX, 0, 0, 1)});
    rows.push_back('{OP_MUL, -1, 0, 1, 0, 1, known(0, 0, 0, 0)});
    rows.push_back('{OP_MUL, 32'sh12345678, -32'sh0abcdef0, -32'sh1357, 32'sh2468ace, 0,
                     known(0, 0, 0, 0)});
    rows.push_back('{OP_DIV, ONE, ONE, 0, 0, 1, known(0, 0, 1, 0)});
    rows.push_back('{OP_DIV, WMAX, WMIN, 0, 0, 1, known(0, 0, 1, 0)});
    rows.push_back('{OP_DIV, ONE, 0, ONE, 0, 1, known(ONE, 0, 0, 0)});
    rows.push_back('{OP_DIV, 0, ONE, 0, ONE, 1, known(ONE, 0, 0, 0)});
    rows.push_back('{OP_DIV, ONE, 0, 1, 0, 1, known(WMAX, 0, 0, 1)});
    rows.push_back('{OP_DIV, WMIN, WMIN, WMIN, WMIN, 0, known(0, 0, 0, 0)});
    rows.push_back('{OP_DIV, WMAX, -7, 3, WMIN, 0, known(0, 0, 0, 0)});
    rows.push_back('{OP_DIV, -ONE, 0, 3 * ONE, 0, 0, known(0, 0, 0, 0)});

    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (rows[i]) begin
      next_is_known.push_back(rows[i].known);
      if (rows[i].known) next_known.push_back(rows[i].res);
      issue(rows[i].op, rows[i].ar, rows[i].ai, rows[i].br, rows[i].bi, 0);
    end

    for (int n = 0; n < 700; n++) begin
      idle_pct = (n < 233) ? 9 : (n < 466) ? 63 : 0;
      kind = $urandom_range(3);
      op = op_t'($urandom_range(3));
      br = rand_part(kind);
      bi = rand_part(kind);
      if (op == OP_DIV && $urandom_range(15) == 0) begin
        br = 0;
        bi = 0;
      end
      next_is_known.push_back(0);
      issue(op, rand_part(kind), rand_part(kind), br, bi, idle_pct);
    end
    start <= 0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** complex_arithmetic_unit: PASSED **");
    end else begin
      $display("** complex_arithmetic_unit: FAILED **");
    end
    $finish;
  end
endmodule

/* filelist.f */
rtl/core/cau_pkg.sv
rtl/core/cau_div_step.sv
rtl/core/cau_sat.sv
rtl/core/complex_arithmetic_unit.sv
bench/testbench.sv
